FILE: sv/abst_pkg.sv
package abst_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned MaxResults  = 16;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned OpW         = 3;
  localparam int unsigned KindW       = 2;
  localparam int unsigned QDepth      = 2;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 3'd0,
    OP_IN     = 3'd1,
    OP_PRE    = 3'd2,
    OP_POST   = 3'd3,
    OP_SLOT   = 3'd4
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_OK    = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_KEY   = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

  // one classified request handed from front to back
  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [KeyW-1:0] key;
  } req_t;

endpackage

FILE: sv/array_binary_search_tree.sv
// Insert: the result is registered when the request is taken; the tree walk then does S_WALK and S_LINK per level.
// Traversal: each key passes the link/stack step, the key RAM read and S_EMIT, which holds while the output stalls.
// Sequential: one request at a time in the back end; a 2-word queue decouples the front.
// Unknown ops are dropped at the front with no result.
// Reset (asynchronous, active low) empties the tree and the queue; no clearing pass.
module array_binary_search_tree #(
  parameter int unsigned Capacity = abst_pkg::CapacityDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [abst_pkg::OpW-1:0]        op_i,
  input  logic signed [abst_pkg::KeyW-1:0] key_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [abst_pkg::KindW-1:0]      kind_o,
  output logic signed [abst_pkg::KeyW-1:0] out_key_o,
  output logic                            last_o
);

  logic           q_valid, q_ready;
  abst_pkg::req_t q_req;

  abst_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .key_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  abst_back #(.Capacity(Capacity)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid_o, .out_ready_i, .kind_o, .out_key_o, .last_o
  );

endmodule

FILE: sv/abst_front.sv
module abst_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [abst_pkg::OpW-1:0]  op_i,
  input  logic signed [abst_pkg::KeyW-1:0] key_i,
  output logic                      q_valid_o,
  input  logic                      q_ready_i,
  output abst_pkg::req_t            q_req_o
);

  localparam int unsigned QD = abst_pkg::QDepth;
  localparam int unsigned PW = $clog2(QD);

  abst_pkg::req_t  mem_q [QD];
  logic [PW-1:0]   wr_q, rd_q;
  logic [PW:0]     cnt_q;
  logic            push, pop, known;

  // drop unknown ops here; they never reach the back end
  assign known      = (op_i <= abst_pkg::OpW'(abst_pkg::OP_SLOT));
  assign in_ready_o = (cnt_q != (PW+1)'(QD));
  assign push       = in_valid_i && in_ready_o && known;
  assign pop        = q_valid_o && q_ready_i;
  assign q_valid_o  = (cnt_q != '0);
  assign q_req_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{op: op_i, key: key_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (PW+1)'(QD)) |-> !push) else $error("queue overflow");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(QD)) else $error("queue count out of range");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != '0) else $error("pop from empty queue");

endmodule

FILE: sv/abst_back.sv
module abst_back #(
  parameter int unsigned Capacity = abst_pkg::CapacityDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  output logic                      q_ready_o,
  input  abst_pkg::req_t            q_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [abst_pkg::KindW-1:0] kind_o,
  output logic signed [abst_pkg::KeyW-1:0] out_key_o,
  output logic                      last_o
);

  localparam int unsigned SW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned EW = $clog2(abst_pkg::MaxResults + 1);
  localparam int unsigned KW = abst_pkg::KeyW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_WALK  = 8'b00000010,
    S_LINK  = 8'b00000100,
    S_DESC  = 8'b00001000,
    S_POP   = 8'b00010000,
    S_VISIT = 8'b00100000,
    S_READ  = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_e;

  state_e          st_q, st_d;
  logic [KW-1:0]   key_mem [Capacity];
  logic [SW-1:0]   lft_q [Capacity];
  logic [SW-1:0]   rgt_q [Capacity];
  logic [SW-1:0]   stk_slot [Capacity];
  logic            stk_done [Capacity];
  logic [CW-1:0]   used_q, used_d;
  logic [CW-1:0]   sp_q, sp_d;
  logic [SW-1:0]   cur_q, cur_d, idx_q, idx_d;
  logic [EW-1:0]   emit_q, emit_d;
  logic [abst_pkg::OpW-1:0] op_q, op_d;
  logic [KW-1:0]   nkey_q, nkey_d;
  logic            have_q, have_d;
  logic [SW-1:0]   pend_slot_q, pend_slot_d;
  logic            pend_last_q, pend_last_d;
  logic            ovalid_q, oload;
  logic [abst_pkg::KindW-1:0] okind_q, okind_d;
  logic [KW-1:0]   okey_q, okey_d;
  logic            olast_q, olast_d;
  logic            oslot_free, acc, is_ins, kw_en;
  logic [SW-1:0]   top_slot;
  logic            top_done;
  logic            stk_full;
  logic            cap_hit;
  logic [KW-1:0]   rkey_q;
  logic [SW-1:0]   raddr;
  logic            walk_lt;
  state_e          ret_st;
  logic            ll_we, rl_we, pa_we, pb_we, dn_we;
  logic [SW-1:0]   pa_idx, pb_idx, dn_idx, pa_slot, pb_slot;
  logic [CW-1:0]   p;

  assign oslot_free  = !ovalid_q || out_ready_i;
  assign q_ready_o   = (st_q == S_IDLE) && oslot_free;
  assign acc         = q_valid_i && q_ready_o;
  assign is_ins      = (q_req_i.op == abst_pkg::OpW'(abst_pkg::OP_INSERT));
  assign kw_en       = acc && is_ins && (used_q != CW'(Capacity));
  assign out_valid_o = ovalid_q;
  assign kind_o      = okind_q;
  assign out_key_o   = okey_q;
  assign last_o      = olast_q;
  assign top_slot    = stk_slot[SW'(sp_q - 1'b1)];
  assign top_done    = stk_done[SW'(sp_q - 1'b1)];
  assign stk_full    = (sp_q == CW'(Capacity));
  assign cap_hit     = (emit_q == EW'(abst_pkg::MaxResults - 1));
  assign ret_st      = (op_q == abst_pkg::OpW'(abst_pkg::OP_IN))   ? S_DESC :
                       (op_q == abst_pkg::OpW'(abst_pkg::OP_SLOT)) ? S_VISIT : S_POP;

  // a key read goes through one registered port
  assign raddr   = (st_q == S_WALK) ? cur_q : pend_slot_q;
  assign walk_lt = $signed(rkey_q) < $signed(nkey_q);

  always_ff @(posedge clk_i) begin
    rkey_q <= key_mem[raddr];
    if (kw_en) key_mem[used_q[SW-1:0]] <= q_req_i.key;
  end

  always_ff @(posedge clk_i) begin
    if (kw_en) begin
      lft_q[used_q[SW-1:0]] <= '0;
      rgt_q[used_q[SW-1:0]] <= '0;
    end
    if (ll_we) lft_q[cur_q] <= idx_q;
    if (rl_we) rgt_q[cur_q] <= idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (dn_we) stk_done[dn_idx] <= 1'b1;
    if (pa_we) begin
      stk_slot[pa_idx] <= pa_slot; stk_done[pa_idx] <= 1'b0;
    end
    if (pb_we) begin
      stk_slot[pb_idx] <= pb_slot; stk_done[pb_idx] <= 1'b0;
    end
  end

  always_comb begin
    st_d        = st_q;
    used_d      = used_q;
    sp_d        = sp_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    emit_d      = emit_q;
    op_d        = op_q;
    nkey_d      = nkey_q;
    have_d      = have_q;
    pend_slot_d = pend_slot_q;
    pend_last_d = pend_last_q;
    oload       = 1'b0;
    okind_d     = okind_q;
    okey_d      = okey_q;
    olast_d     = olast_q;
    ll_we = 1'b0; rl_we = 1'b0;
    pa_we = 1'b0; pb_we = 1'b0; dn_we = 1'b0;
    pa_idx = '0; pb_idx = '0; dn_idx = '0; pa_slot = '0; pb_slot = '0;
    p = '0;
    unique case (st_q)
      S_IDLE: if (acc) begin
        op_d    = q_req_i.op;
        nkey_d  = q_req_i.key;
        emit_d  = '0;
        cur_d   = '0;
        okey_d  = '0;
        olast_d = 1'b1;
        if (is_ins) begin
          oload = 1'b1;
          if (used_q == CW'(Capacity)) begin
            okind_d = abst_pkg::KIND_FULL;
          end else begin
            okind_d = abst_pkg::KIND_OK;
            idx_d   = used_q[SW-1:0];
            used_d  = used_q + 1'b1;
            if (used_q != '0) st_d = S_WALK;
          end
        end else if (used_q == '0) begin
          oload   = 1'b1;
          okind_d = abst_pkg::KIND_EMPTY;
        end else begin
          unique case (q_req_i.op)
            abst_pkg::OpW'(abst_pkg::OP_IN): begin
              sp_d = '0; have_d = 1'b1; st_d = S_DESC;
            end
            abst_pkg::OpW'(abst_pkg::OP_SLOT): st_d = S_VISIT;
            default: begin
              pa_we = 1'b1; pa_idx = '0; pa_slot = '0;
              sp_d = CW'(1); st_d = S_POP;
            end
          endcase
        end
      end
      // insert: S_WALK reads the slot key, S_LINK decides
      S_WALK: st_d = S_LINK;
      S_LINK: begin
        if (walk_lt) begin
          if (rgt_q[cur_q] == '0) begin
            rl_we = 1'b1; st_d = S_IDLE;
          end else begin
            cur_d = rgt_q[cur_q]; st_d = S_WALK;
          end
        end else begin
          if (lft_q[cur_q] == '0) begin
            ll_we = 1'b1; st_d = S_IDLE;
          end else begin
            cur_d = lft_q[cur_q]; st_d = S_WALK;
          end
        end
      end
      // in-order: push the left spine one slot a cycle, then pop one
      S_DESC: begin
        if (have_q && !stk_full) begin
          pa_we   = 1'b1;
          pa_idx  = sp_q[SW-1:0];
          pa_slot = cur_q;
          sp_d    = sp_q + 1'b1;
          have_d  = (lft_q[cur_q] != '0);
          cur_d   = lft_q[cur_q];
        end else begin
          sp_d        = sp_q - 1'b1;
          pend_slot_d = top_slot;
          have_d      = (rgt_q[top_slot] != '0);
          cur_d       = rgt_q[top_slot];
          pend_last_d = cap_hit || (!have_d && sp_d == '0);
          st_d        = S_READ;
        end
      end
      // pre/post order stack step
      S_POP: begin
        if (op_q == abst_pkg::OpW'(abst_pkg::OP_POST) && top_done) begin
          sp_d        = sp_q - 1'b1;
          pend_slot_d = top_slot;
          pend_last_d = cap_hit || (sp_d == '0);
          st_d        = S_READ;
        end else begin
          p = sp_q - 1'b1;
          if (op_q == abst_pkg::OpW'(abst_pkg::OP_POST)) begin
            dn_we  = 1'b1;
            dn_idx = p[SW-1:0];
            p      = p + 1'b1;
          end else begin
            pend_slot_d = top_slot;
            st_d        = S_READ;
          end
          if (rgt_q[top_slot] != '0 && p != CW'(Capacity)) begin
            pa_we = 1'b1; pa_idx = p[SW-1:0]; pa_slot = rgt_q[top_slot];
            p = p + 1'b1;
          end
          if (lft_q[top_slot] != '0 && p != CW'(Capacity)) begin
            pb_we = 1'b1; pb_idx = p[SW-1:0]; pb_slot = lft_q[top_slot];
            p = p + 1'b1;
          end
          sp_d        = p;
          pend_last_d = cap_hit || (p == '0);
        end
      end
      S_VISIT: begin
        pend_slot_d = cur_q;
        cur_d       = cur_q + 1'b1;
        pend_last_d = cap_hit || ((CW'(cur_q) + CW'(1)) == used_q);
        st_d        = S_READ;
      end
      S_READ: st_d = S_EMIT;
      // hold the key word until the output register is free
      S_EMIT: begin
        if (oslot_free) begin
          oload   = 1'b1;
          okind_d = abst_pkg::KIND_KEY;
          okey_d  = rkey_q;
          olast_d = pend_last_q;
          emit_d  = emit_q + 1'b1;
          st_d    = pend_last_q ? S_IDLE : ret_st;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      used_q      <= '0;
      sp_q        <= '0;
      cur_q       <= '0;
      idx_q       <= '0;
      emit_q      <= '0;
      op_q        <= '0;
      nkey_q      <= '0;
      have_q      <= 1'b0;
      pend_slot_q <= '0;
      pend_last_q <= 1'b0;
      ovalid_q    <= 1'b0;
      okind_q     <= '0;
      okey_q      <= '0;
      olast_q     <= 1'b0;
    end else begin
      st_q        <= st_d;
      used_q      <= used_d;
      sp_q        <= sp_d;
      cur_q       <= cur_d;
      idx_q       <= idx_d;
      emit_q      <= emit_d;
      op_q        <= op_d;
      nkey_q      <= nkey_d;
      have_q      <= have_d;
      pend_slot_q <= pend_slot_d;
      pend_last_q <= pend_last_d;
      ovalid_q    <= oload || (ovalid_q && !out_ready_i);
      if (oload) begin
        okind_q <= okind_d;
        okey_q  <= okey_d;
        olast_q <= olast_d;
      end
    end
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(Capacity)) else $error("slot count out of range");
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= CW'(Capacity)) else $error("stack pointer out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ready_i) |=> ovalid_q && $stable(okey_q) && $stable(okind_q)
    && $stable(olast_q)) else $error("result changed while stalled");
  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready_o |-> st_q == S_IDLE) else $error("request taken while busy");

endmodule
